// ----- hdl/rbd_pkg.sv -----
// Package for the 2x2 RGBA box downsampler: pixel and pair-sum types,
// the pipeline stage record and the register index codes.
// No dependencies.
package rbd_pkg;

  localparam int CHAN_N          = 4;
  localparam int PIX_W           = 8;
  localparam int PAIR_W          = PIX_W + 1;
  localparam int QUAD_W          = PIX_W + 2;
  localparam int CFG_W           = 12;
  localparam int ROW_W           = 11;
  localparam int MAX_ROWS        = 2048;
  localparam int MAX_LINE_PIXELS_DEF = 2048;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  // Register index, taken from paddr[2].
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd2048;

  typedef logic [CHAN_N-1:0][PIX_W-1:0]  pixel_t;
  typedef logic [CHAN_N-1:0][PAIR_W-1:0] pair_sum_t;

  // Bottom-pair record handed from the front stage to the output stage.
  typedef struct packed {
    logic      valid;
    pair_sum_t pair;
    logic      frame_end;
  } stage_t;

endpackage

// ----- hdl/rbd_cfg.sv -----
// Configuration registers of the downsampler behind an APB-style port,
// plus the saturated, even-rounded frame limits. Depends on rbd_pkg.
module rbd_cfg #(
  parameter int MAX_LINE_PIXELS = rbd_pkg::MAX_LINE_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rbd_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [rbd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [rbd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [$clog2(MAX_LINE_PIXELS):0]  eff_width,
  output logic [rbd_pkg::CFG_W-1:0]         eff_height
);
  import rbd_pkg::*;

  localparam int CW    = $clog2(MAX_LINE_PIXELS) + 1;
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CMP_W-1:0] W_LIM = CMP_W'(MAX_LINE_PIXELS & ~1);
  localparam logic [CFG_W-1:0] H_LIM = CFG_W'(MAX_ROWS);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             wr;
  logic [CMP_W-1:0] w_even;
  logic [CMP_W-1:0] w_sat;
  logic [CFG_W-1:0] h_even;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[CFG_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = {{(APB_DATA_W-CFG_W){1'b0}}, frame_width};
      REG_FRAME_HEIGHT: prdata = {{(APB_DATA_W-CFG_W){1'b0}}, frame_height};
      default:          prdata = '0;
    endcase
  end

  // Bit 0 is ignored, then the value is clamped to the supported range.
  always_comb begin
    w_even = CMP_W'({frame_width[CFG_W-1:1], 1'b0});
    if (w_even < CMP_W'(2))  w_sat = CMP_W'(2);
    else if (w_even > W_LIM) w_sat = W_LIM;
    else                     w_sat = w_even;
    eff_width = w_sat[CW-1:0];

    h_even = {frame_height[CFG_W-1:1], 1'b0};
    if (h_even < CFG_W'(2))  eff_height = CFG_W'(2);
    else if (h_even > H_LIM) eff_height = H_LIM;
    else                     eff_height = h_even;
  end

endmodule

// ----- hdl/rbd_line_store.sv -----
// Half-width line store of horizontal pair sums: one write port and one
// read port with registered read data. Depends on nothing.
module rbd_line_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 36
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/rbd_pair_stage.sv -----
// Front stage: column and row counters, the held left pixel, pair sums,
// line store access and the bottom-pair stage register. Depends on rbd_pkg.
module rbd_pair_stage #(
  parameter int MAX_LINE_PIXELS = rbd_pkg::MAX_LINE_PIXELS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic [$clog2(MAX_LINE_PIXELS):0]         eff_width,
  input  logic [rbd_pkg::CFG_W-1:0]                eff_height,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  rbd_pkg::pixel_t                          pixel,
  input  logic                                     take,
  output rbd_pkg::stage_t                          stage,
  output logic                                     mem_wr_en,
  output logic                                     mem_rd_en,
  output logic [$clog2(MAX_LINE_PIXELS/2)-1:0]     mem_addr,
  output rbd_pkg::pair_sum_t                       mem_wr_data
);
  import rbd_pkg::*;

  localparam int COL_W  = $clog2(MAX_LINE_PIXELS);
  localparam int CW     = COL_W + 1;
  localparam int ADDR_W = $clog2(MAX_LINE_PIXELS / 2);

  logic [COL_W-1:0] column_count;
  logic [COL_W-1:0] column_count_next;
  logic [ROW_W-1:0] row_count;
  logic [ROW_W-1:0] row_count_next;
  pixel_t           held_left_pixel;
  pair_sum_t        pair;
  logic [CW-1:0]    col_inc;
  logic [CFG_W-1:0] row_inc;
  logic             col_last;
  logic             row_last;
  logic             accept;
  logic             produce;
  stage_t           stage_next;

  assign in_ready = ~stage.valid | take;
  assign accept   = in_valid & in_ready;

  always_comb begin
    for (int k = 0; k < CHAN_N; k++) begin
      pair[k] = {1'b0, held_left_pixel[k]} + {1'b0, pixel[k]};
    end
  end

  assign col_inc  = {1'b0, column_count} + CW'(1);
  assign row_inc  = {1'b0, row_count} + CFG_W'(1);
  assign col_last = col_inc >= eff_width;
  assign row_last = row_inc >= eff_height;

  // Even rows store the pair sum; odd rows fetch the one stored above.
  assign produce     = accept & column_count[0] & row_count[0];
  assign mem_wr_en   = accept & column_count[0] & ~row_count[0];
  assign mem_rd_en   = produce;
  assign mem_addr    = column_count[ADDR_W:1];
  assign mem_wr_data = pair;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (accept) begin
      if (col_last) begin
        column_count_next = '0;
        row_count_next    = row_last ? '0 : row_inc[ROW_W-1:0];
      end else begin
        column_count_next = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    stage_next = stage;
    if (produce) begin
      stage_next.valid     = 1'b1;
      stage_next.pair      = pair;
      stage_next.frame_end = col_last & row_last;
    end else if (take) begin
      stage_next.valid = 1'b0;
    end
  end

  // Only the valid bit of the stage record needs a reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      held_left_pixel <= '0;
      stage.valid     <= 1'b0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      stage.valid  <= stage_next.valid;
      if (accept & ~column_count[0]) begin
        held_left_pixel <= pixel;
      end
    end
    stage.pair      <= stage_next.pair;
    stage.frame_end <= stage_next.frame_end;
  end

endmodule

// ----- hdl/rbd_average_out.sv -----
// Output stage: adds the stored top pair sum to the bottom pair sum,
// divides by four and holds the result item in the output register.
// Depends on rbd_pkg.
module rbd_average_out (
  input  logic               clk,
  input  logic               rst,
  input  rbd_pkg::stage_t    stage,
  input  rbd_pkg::pair_sum_t above,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output rbd_pkg::pixel_t    pixel_out,
  output logic               frame_end
);
  import rbd_pkg::*;

  logic              load;
  logic              out_valid_next;
  logic [QUAD_W-1:0] quad [CHAN_N];

  assign take = ~out_valid | out_ready;
  assign load = stage.valid & take;

  always_comb begin
    for (int k = 0; k < CHAN_N; k++) begin
      quad[k] = {1'b0, above[k]} + {1'b0, stage.pair[k]};
    end
  end

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int k = 0; k < CHAN_N; k++) begin
        pixel_out[k] <= quad[k][QUAD_W-1:2];
      end
      frame_end <= stage.frame_end;
    end
  end

endmodule

// ----- hdl/rgba_box_downsample_2x2.sv -----
// Top level of the 2x2 RGBA box downsampler: configuration port, front
// stage, line store and output stage. Depends on rbd_pkg and submodules.
//
// This block takes a raster-order frame of four-channel 8-bit pixels, one
// pixel per input item, and returns a half-width, half-height frame in which
// each channel is the sum over a 2x2 block divided by four with truncation.
// It accepts one item per clock cycle unless the output stalls. On even input
// rows the sum of each horizontal pixel pair goes into a half-width line
// store; on odd rows the stored sum is read back and added to the current
// pair sum, so one result item leaves for each pair of odd-row pixels, via
// the stage register and line store read, then the output register. The
// line store sees at most one access per item, a write on even rows or a
// read on odd rows, which is what sets the rate of one item per cycle when
// the output does not stall. The output register lets a new item enter while
// a finished result still waits. frame_end marks the last result of a frame.
// Width and height are written through the APB-style port at byte addresses
// 0 and 4; bit 0 of each is ignored, and values are clamped to 2 up to
// MAX_LINE_PIXELS (width) and 2 up to 2048 (height). Registers should be
// written only between frames. There is no clearing pass after reset.
module rgba_box_downsample_2x2 #(
  parameter int MAX_LINE_PIXELS = rbd_pkg::MAX_LINE_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbd_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rbd_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rbd_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [rbd_pkg::PIX_W-1:0]      chan0_in,
  input  logic [rbd_pkg::PIX_W-1:0]      chan1_in,
  input  logic [rbd_pkg::PIX_W-1:0]      chan2_in,
  input  logic [rbd_pkg::PIX_W-1:0]      chan3_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rbd_pkg::PIX_W-1:0]      chan0_out,
  output logic [rbd_pkg::PIX_W-1:0]      chan1_out,
  output logic [rbd_pkg::PIX_W-1:0]      chan2_out,
  output logic [rbd_pkg::PIX_W-1:0]      chan3_out,
  output logic                           frame_end
);
  import rbd_pkg::*;

  // The line store holds one pair sum per two input columns.
  localparam int LINE_ENTRIES = MAX_LINE_PIXELS / 2;
  localparam int ADDR_W       = $clog2(LINE_ENTRIES);
  localparam int CW           = $clog2(MAX_LINE_PIXELS) + 1;

  logic [CW-1:0]     eff_width;
  logic [CFG_W-1:0]  eff_height;
  pixel_t            pixel_in;
  pixel_t            pixel_out;
  stage_t            stage;
  logic              take;
  logic              mem_wr_en;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_addr;
  pair_sum_t         mem_wr_data;
  pair_sum_t         mem_rd_data;

  // Channel 0 sits in the low byte, as in a packed little-endian pixel.
  assign pixel_in = {chan3_in, chan2_in, chan1_in, chan0_in};

  assign chan0_out = pixel_out[0];
  assign chan1_out = pixel_out[1];
  assign chan2_out = pixel_out[2];
  assign chan3_out = pixel_out[3];

  rbd_cfg #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_width (eff_width),
    .eff_height(eff_height)
  );

  rbd_pair_stage #(
    .MAX_LINE_PIXELS(MAX_LINE_PIXELS)
  ) u_pair_stage (
    .clk        (clk),
    .rst        (rst),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel_in),
    .take       (take),
    .stage      (stage),
    .mem_wr_en  (mem_wr_en),
    .mem_rd_en  (mem_rd_en),
    .mem_addr   (mem_addr),
    .mem_wr_data(mem_wr_data)
  );

  // A read on an odd row always follows the even-row write of the same
  // entry by at least one item, so no forwarding path is needed.
  rbd_line_store #(
    .DEPTH (LINE_ENTRIES),
    .ADDR_W(ADDR_W),
    .DATA_W($bits(pair_sum_t))
  ) u_line_store (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_addr),
    .rd_data(mem_rd_data)
  );

  rbd_average_out u_average_out (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .above    (mem_rd_data),
    .take     (take),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .pixel_out(pixel_out),
    .frame_end(frame_end)
  );

endmodule

// ----- dv/tb_rgba_box_downsample_2x2.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for rgba_box_downsample_2x2: streams raster frames through the
// pixel port, predicts every 2x2 average in its own model and checks each result item.
// Depends on rbd_pkg and the RTL of the block; nothing else.
module tb_rgba_box_downsample_2x2;
  import rbd_pkg::*;

  localparam int LINE_SLOTS     = MAX_LINE_PIXELS_DEF / 2;
  localparam int WIDEST_LINE    = MAX_LINE_PIXELS_DEF & ~1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int RANDOM_ITEMS   = 720;
  localparam int MAX_REPORTS    = 10;

  // One expected output pixel: four truncated channel averages and the end-of-frame flag.
  typedef struct packed {
    pixel_t avg;
    logic   last;
  } box_avg_t;

  typedef enum int {FILL_RANDOM, FILL_EXTREMES, FILL_BRIGHT} fill_e;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [PIX_W-1:0]      chan0_in;
  logic [PIX_W-1:0]      chan1_in;
  logic [PIX_W-1:0]      chan2_in;
  logic [PIX_W-1:0]      chan3_in;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      chan0_out;
  logic [PIX_W-1:0]      chan1_out;
  logic [PIX_W-1:0]      chan2_out;
  logic [PIX_W-1:0]      chan3_out;
  logic                  frame_end;

  // Idle knobs, in percent: chance per cycle that the pixel source holds back, and chance
  // per cycle that the result sink refuses an item.
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;

  // Model state: register shadows, raster counters, the held left pixel and the line of
  // pair sums from the last even row.
  logic [CFG_W-1:0] reg_width;
  logic [CFG_W-1:0] reg_height;
  int unsigned      cur_col;
  int unsigned      cur_row;
  pixel_t           left_pixel;
  pair_sum_t        upper_pair_sums [LINE_SLOTS];
  box_avg_t         pending_avgs [$];

  int unsigned pixels_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_seen   = 0;
  int unsigned error_count   = 0;
  int          idle_cycles   = 0;

  box_avg_t want;
  box_avg_t got;

  rgba_box_downsample_2x2 u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .chan0_in  (chan0_in),
    .chan1_in  (chan1_in),
    .chan2_in  (chan2_in),
    .chan3_in  (chan3_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .chan0_out (chan0_out),
    .chan1_out (chan1_out),
    .chan2_out (chan2_out),
    .chan3_out (chan3_out),
    .frame_end (frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The block ignores bit 0 of both sizes and clamps them, width to the line store and
  // height to 2048 lines.
  function automatic int unsigned active_width();
    int unsigned w;
    w = 32'(reg_width) & 32'hFFE;
    if (w < 2) w = 2;
    if (w > WIDEST_LINE) w = WIDEST_LINE;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = 32'(reg_height) & 32'hFFE;
    if (h < 2) h = 2;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  // Advances the model by one accepted pixel. Even columns are held; odd columns form a
  // pair sum, which an even row stores and an odd row adds to the stored sum above it.
  function automatic void fold_pixel(input pixel_t px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       slot;
    int                k;
    pair_sum_t         pair;
    logic [QUAD_W-1:0] quad;
    box_avg_t          res;
    w = active_width();
    h = active_height();
    if (cur_col[0] == 1'b0) begin
      left_pixel = px;
    end else begin
      slot = (cur_col >> 1) % LINE_SLOTS;
      for (k = 0; k < CHAN_N; k++) begin
        pair[k] = {1'b0, left_pixel[k]} + {1'b0, px[k]};
      end
      if (cur_row[0] == 1'b0) begin
        upper_pair_sums[slot] = pair;
      end else begin
        for (k = 0; k < CHAN_N; k++) begin
          quad = {1'b0, upper_pair_sums[slot][k]} + {1'b0, pair[k]};
          res.avg[k] = quad[QUAD_W-1:2];
        end
        res.last = (cur_row + 1 >= h) && (cur_col + 1 >= w);
        pending_avgs.push_back(res);
      end
    end
    // A counter that already sits at or past a shrunken limit wraps at this advance.
    cur_col++;
    if (cur_col >= w) begin
      cur_col = 0;
      cur_row++;
      if (cur_row >= h) cur_row = 0;
    end
  endfunction

  function automatic pixel_t make_pixel(input fill_e fill);
    pixel_t px;
    int     k;
    px = $urandom;
    for (k = 0; k < CHAN_N; k++) begin
      if (fill == FILL_EXTREMES) px[k] = $urandom_range(1) ? 8'hFF : 8'h00;
      else if (fill == FILL_BRIGHT) px[k] = PIX_W'($urandom_range(255, 240));
    end
    return px;
  endfunction

  // Size word for a random frame. Upper bits of the data bus are filled with noise since
  // the block keeps only the low twelve.
  function automatic logic [APB_DATA_W-1:0] random_size_word(input int unsigned top);
    logic [APB_DATA_W-1:0] word;
    word = $urandom;
    case ($urandom_range(9))
      0:       word[CFG_W-1:0] = CFG_W'($urandom_range(1));
      1:       word[CFG_W-1:0] = CFG_W'(2 * $urandom_range(top / 2, 1) + 1);
      default: word[CFG_W-1:0] = CFG_W'(2 * $urandom_range(top / 2, 1));
    endcase
    return word;
  endfunction

  function automatic void note_error(input string what);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  // Offers one pixel and returns once it is accepted. in_valid is left high so that a
  // following pixel with no gap goes out on the very next cycle.
  task automatic send_pixel(input pixel_t px);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    chan0_in <= px[0];
    chan1_in <= px[1];
    chan2_in <= px[2];
    chan3_in <= px[3];
    do @(posedge clk); while (!in_ready);
    fold_pixel(px);
    pixels_sent++;
  endtask

  task automatic send_count(input int unsigned count, input fill_e fill);
    repeat (count) send_pixel(make_pixel(fill));
  endtask

  // Sends pixels until the raster counters are back at the top-left corner.
  task automatic send_to_frame_start(input fill_e fill);
    do send_pixel(make_pixel(fill)); while (!(cur_col == 0 && cur_row == 0));
  endtask

  // Stops the source, waits for every predicted result, then lets the pipeline settle in
  // case a pixel that makes no result is still on its way through.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the access edge.
  task automatic write_reg(input logic idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_FRAME_WIDTH) reg_width = data[CFG_W-1:0];
    else reg_height = data[CFG_W-1:0];
    @(posedge clk);
  endtask

  // Width stays at its reset value through 40 pixels of the first even row, so the
  // column counter must not wrap early; the height write of 1 rounds down to 0 and clamps
  // to 2. The width then shrinks to 4, so the next pixel closes the row and the odd row
  // ends the frame.
  task automatic test_default_width();
    set_idle(35, 35);
    write_reg(REG_FRAME_HEIGHT, 32'd1);
    send_count(40, FILL_RANDOM);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 32'd4);
    send_to_frame_start(FILL_RANDOM);
    wait_drained();
  endtask

  // Smallest frames with saturated, empty and bit-alternating channels, where truncation
  // of the divide by four shows up, then an odd width and height that round down.
  task automatic test_pixel_extremes();
    set_idle(0, 0);
    write_reg(REG_FRAME_WIDTH, 32'd2);
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    repeat (4) send_pixel({4{8'hFF}});
    repeat (4) send_pixel({4{8'h00}});
    send_pixel({8'h55, 8'hAA, 8'h01, 8'hFF});
    send_pixel({8'hAA, 8'h55, 8'h00, 8'hFF});
    send_pixel({8'h55, 8'hAA, 8'h01, 8'hFF});
    send_pixel({8'hAA, 8'h55, 8'h01, 8'hFE});
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 32'hFFFF_F007);
    write_reg(REG_FRAME_HEIGHT, 32'd3);
    send_to_frame_start(FILL_EXTREMES);
    wait_drained();
  endtask

  // Sizes at and beyond both ends. A width of 0 clamps to 2 under an all-ones height that
  // clamps to 2048 lines: eight rows go by with no frame end, then the height shrinks to
  // 8 so the row counter wraps after the next even row. An all-ones width clamps to the
  // full line store: 64 pixels of the even row go by without a wrap, then the width
  // shrinks to 6 and the odd row closes the frame.
  task automatic test_clamped_sizes();
    set_idle(65, 0);
    write_reg(REG_FRAME_WIDTH, 32'd0);
    write_reg(REG_FRAME_HEIGHT, 32'h0000_0FFF);
    send_count(16, FILL_RANDOM);
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, 32'd8);
    send_to_frame_start(FILL_RANDOM);
    wait_drained();
    set_idle(0, 65);
    write_reg(REG_FRAME_WIDTH, 32'h0000_0FFF);
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    send_count(64, FILL_BRIGHT);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 32'd6);
    send_to_frame_start(FILL_BRIGHT);
    wait_drained();
  endtask

  // Sizes shrunk in the middle of a frame. Only shrinking is done, and only where the odd
  // row still reads line entries that the even row above it wrote.
  task automatic test_resize_mid_frame();
    set_idle(35, 35);
    write_reg(REG_FRAME_WIDTH, 32'd8);
    write_reg(REG_FRAME_HEIGHT, 32'd4);
    // Whole even row, then six pixels of the odd row: the column counter then stands at 6,
    // past the new width of 4, and must wrap after one more pixel.
    send_count(8, FILL_RANDOM);
    send_count(6, FILL_RANDOM);
    wait_drained();
    write_reg(REG_FRAME_WIDTH, 32'd4);
    send_to_frame_start(FILL_RANDOM);
    wait_drained();
    // Three rows of an 8-row frame, then the height drops to 2 at the start of row 3, so
    // that row must flag the frame end and the row counter must wrap after it.
    write_reg(REG_FRAME_HEIGHT, 32'd8);
    send_count(12, FILL_RANDOM);
    wait_drained();
    write_reg(REG_FRAME_HEIGHT, 32'd2);
    send_to_frame_start(FILL_RANDOM);
    wait_drained();
  endtask

  // Random small frames with random content, rotating through the idle phases. Some
  // frames pause midway until every expected result has come out.
  task automatic test_random_frames();
    int unsigned goal;
    int unsigned frame_idx;
    int unsigned frame_pixels;
    int unsigned sent_in_frame;
    int          pause_at;
    fill_e       fill;
    goal      = pixels_sent + RANDOM_ITEMS;
    frame_idx = 0;
    while (pixels_sent < goal) begin
      case (frame_idx % 4)
        0:       set_idle(0, 0);
        1:       set_idle(65, 0);
        2:       set_idle(0, 65);
        default: set_idle(35, 35);
      endcase
      wait_drained();
      write_reg(REG_FRAME_WIDTH, random_size_word(24));
      write_reg(REG_FRAME_HEIGHT, random_size_word(8));
      case ($urandom_range(9))
        0:       fill = FILL_EXTREMES;
        1:       fill = FILL_BRIGHT;
        default: fill = FILL_RANDOM;
      endcase
      frame_pixels  = active_width() * active_height();
      pause_at      = $urandom_range(1) ? int'($urandom_range(frame_pixels - 1)) : -1;
      sent_in_frame = 0;
      do begin
        if (int'(sent_in_frame) == pause_at) wait_drained();
        send_pixel(make_pixel(fill));
        sent_in_frame++;
      end while (!(cur_col == 0 && cur_row == 0));
      frame_idx++;
    end
    wait_drained();
  endtask

  // The sink stalls at random according to the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Every accepted result is matched against the oldest predicted average, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      got.avg  = {chan3_out, chan2_out, chan1_out, chan0_out};
      got.last = frame_end;
      if (pending_avgs.size() == 0) begin
        note_error($sformatf("result with no expected item: %h frame_end %b",
                             got.avg, got.last));
      end else begin
        want = pending_avgs.pop_front();
        for (int k = 0; k < CHAN_N; k++) begin
          if (got.avg[k] !== want.avg[k]) begin
            note_error($sformatf("result %0d chan%0d_out expected %0d got %0d",
                                 results_seen, k, want.avg[k], got.avg[k]));
          end
        end
        if (got.last !== want.last) begin
          note_error($sformatf("result %0d frame_end expected %b got %b",
                               results_seen, want.last, got.last));
        end
        if (want.last) frames_seen++;
        results_seen++;
      end
    end
  end

  // Ends the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, pending_avgs.size());
      $display("rgba_box_downsample_2x2 verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    in_valid <= 1'b0;
    chan0_in <= '0;
    chan1_in <= '0;
    chan2_in <= '0;
    chan3_in <= '0;
    reg_width  = FRAME_WIDTH_RST;
    reg_height = FRAME_HEIGHT_RST;
    cur_col    = 0;
    cur_row    = 0;
    left_pixel = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_width();
    test_pixel_extremes();
    test_clamped_sizes();
    test_resize_mid_frame();
    test_random_frames();

    if (pending_avgs.size() != 0) begin
      note_error($sformatf("%0d expected results never arrived", pending_avgs.size()));
    end
    $display("Covered %0d input pixels and %0d averaged pixels over %0d frames,",
             pixels_sent, results_seen, frames_seen);
    $display("with clamped and odd sizes, the widest and tallest settings, resizes mid-frame.");
    if (error_count == 0) begin
      $display("rgba_box_downsample_2x2 verification clean");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("rgba_box_downsample_2x2 verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rbd_pkg.sv
hdl/rbd_cfg.sv
hdl/rbd_line_store.sv
hdl/rbd_pair_stage.sv
hdl/rbd_average_out.sv
hdl/rgba_box_downsample_2x2.sv
dv/tb_rgba_box_downsample_2x2.sv
